@@ design/fgr_pkg.sv @@
// Shared types and constants for the font glyph renderer.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package fgr_pkg;

  // Default sizes of the font memory and the display.
  localparam int FONT_BYTES_DEF      = 4096;
  localparam int DISPLAY_COLUMNS_DEF = 128;
  localparam int DISPLAY_ROWS_DEF    = 64;

  // Limits of the font geometry.
  localparam logic [4:0] MAX_WIDTH_LIMIT  = 5'd16;
  localparam logic [4:0] MAX_HEIGHT_LIMIT = 5'd24;

  // Code drawn for characters outside the font, when the font holds it.
  localparam logic [7:0] DOT_CODE = 8'd46;

  // Input beat actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  // Result beat kinds.
  localparam logic [1:0] KIND_PAGE  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_FIRST_CODE = 2'd2;
  localparam logic [1:0] REG_LAST_CODE  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [4:0] RST_MAX_WIDTH  = 5'd5;
  localparam logic [4:0] RST_HEIGHT     = 5'd8;
  localparam logic [7:0] RST_FIRST_CODE = 8'd32;
  localparam logic [7:0] RST_LAST_CODE  = 8'd127;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_WIDTH,
    S_BYTE,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_byte;
    logic start_draw;
    logic reduce;
    logic load_width;
    logic emit_byte;
    logic emit_done;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_done;
    logic glyph_empty;
    logic byte_stop;
    logic byte_final;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ design/fgr_ctrl.sv @@
// Controller state machine of the font glyph renderer.
// Depends on fgr_pkg for the state, command and status types.
`default_nettype none

module fgr_ctrl
  import fgr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic action,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && action == ACT_DRAW) state_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (sts.mod_done) state_next = S_WIDTH;
      end
      S_WIDTH: begin
        state_next = sts.glyph_empty ? S_DONE : S_BYTE;
      end
      S_BYTE: begin
        if (sts.out_free && (sts.byte_stop || sts.byte_final)) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_byte  = in_valid && action == ACT_LOAD;
        cmd.start_draw = in_valid && action == ACT_DRAW;
      end
      S_REDUCE: cmd.reduce     = 1'b1;
      S_WIDTH:  cmd.load_width = 1'b1;
      S_BYTE:   cmd.emit_byte  = sts.out_free;
      S_DONE:   cmd.emit_done  = sts.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/fgr_datapath.sv @@
// Datapath of the font glyph renderer: configuration registers, font memory,
// address and column/row counters, pixel masking and the output register.
// Depends on fgr_pkg; driven by commands from fgr_ctrl.
`default_nettype none

module fgr_datapath
  import fgr_pkg::*;
#(
  parameter int FONT_BYTES      = FONT_BYTES_DEF,
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF,
  parameter int DISPLAY_ROWS    = DISPLAY_ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  input  wire logic [11:0] font_addr,
  input  wire logic [7:0] font_byte,
  input  wire logic [7:0] pos_x,
  input  wire logic [7:0] pos_y,
  input  wire logic [7:0] char_code,
  input  wire logic       fast_mode,
  input  wire logic       invert,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      column,
  output logic [7:0]      row,
  output logic [7:0]      pixels,
  output logic [7:0]      write_mask,
  output logic [4:0]      glyph_width,
  output logic            clipped,
  output logic            last
);

  localparam int AW = $clog2(FONT_BYTES);
  localparam logic [16:0] FB17 = 17'(FONT_BYTES);
  localparam logic [AW-1:0] ADDR_TOP = AW'(FONT_BYTES - 1);
  localparam logic [8:0] COLS9 = 9'(DISPLAY_COLUMNS);
  localparam logic [9:0] ROWS10 = 10'(DISPLAY_ROWS);

  // Bit mask of the n lowest bits, saturating at a full byte.
  function automatic logic [7:0] low_mask(input logic [4:0] n);
    logic [7:0] m;
    if (n >= 5'd8) m = 8'hFF;
    else m = (8'd1 << n[2:0]) - 8'd1;
    return m;
  endfunction

  // Configuration registers.
  logic [4:0] cfg_max_width;
  logic [4:0] cfg_height;
  logic [7:0] cfg_first;
  logic [7:0] cfg_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_max_width <= RST_MAX_WIDTH;
      cfg_height    <= RST_HEIGHT;
      cfg_first     <= RST_FIRST_CODE;
      cfg_last      <= RST_LAST_CODE;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_MAX_WIDTH:  cfg_max_width <= cfg_data[4:0];
        REG_HEIGHT:     cfg_height    <= cfg_data[4:0];
        REG_FIRST_CODE: cfg_first     <= cfg_data;
        REG_LAST_CODE:  cfg_last      <= cfg_data;
        default:        cfg_last      <= cfg_last;
      endcase
    end
  end

  // Effective font geometry.
  logic [4:0] mw;
  logic [4:0] h;
  logic [1:0] bh;
  logic [6:0] stride;
  logic [5:0] h_up;

  assign mw     = (cfg_max_width > MAX_WIDTH_LIMIT) ? MAX_WIDTH_LIMIT : cfg_max_width;
  assign h      = (cfg_height > MAX_HEIGHT_LIMIT) ? MAX_HEIGHT_LIMIT : cfg_height;
  assign h_up   = {1'b0, h} + 6'd7;
  assign bh     = h_up[4:3];
  assign stride = 7'(mw * bh) + 7'd1;

  // Glyph selection for the incoming character.
  logic [7:0]  code_eff;
  logic [7:0]  code_off;
  logic [14:0] slot_prod;

  always_comb begin
    if (char_code >= cfg_first && char_code <= cfg_last) code_eff = char_code;
    else if (DOT_CODE >= cfg_first && DOT_CODE <= cfg_last) code_eff = DOT_CODE;
    else code_eff = cfg_first;
  end

  assign code_off  = code_eff - cfg_first;
  assign slot_prod = code_off * stride;

  // Draw parameters, glyph base reduction and counters.
  logic [7:0]    x_r;
  logic [7:0]    y_r;
  logic          fast_r;
  logic          inv_r;
  logic [13:0]   prod;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_next;
  logic [AW-1:0] ptr_inc;
  logic [4:0]    vw;
  logic [3:0]    col_i;
  logic [1:0]    row_j;
  logic          clip_r;

  assign sts.mod_done = {3'b000, prod} < FB17;
  assign ptr_inc      = (ptr == ADDR_TOP) ? '0 : ptr + AW'(1);

  always_comb begin
    ptr_next = ptr;
    if (cmd.reduce && sts.mod_done) ptr_next = AW'(prod);
    else if (cmd.load_width || cmd.emit_byte) ptr_next = ptr_inc;
  end

  // Font memory: one write port for loads, read data registered at the
  // next pointer, so rdata always holds the byte at ptr.
  logic [7:0] font_mem [FONT_BYTES];
  logic [7:0] rdata;
  logic       addr_ok;

  assign addr_ok = {5'b00000, font_addr} < FB17;

  always_ff @(posedge clk) begin
    if (cmd.load_byte && addr_ok) font_mem[AW'(font_addr)] <= font_byte;
    rdata <= font_mem[ptr_next];
  end

  // Width byte, saturated to the maximum width.
  logic [4:0] vw_c;

  assign vw_c            = (rdata > {3'b000, mw}) ? mw : rdata[4:0];
  assign sts.glyph_empty = (vw_c == 5'd0) || (bh == 2'd0);

  // Position and masks of the current byte.
  logic [8:0] col9;
  logic [9:0] top10;
  logic [9:0] room;
  logic [3:0] lim;
  logic [4:0] hrem;
  logic [7:0] pix;
  logic [7:0] hmask;
  logic [7:0] smask;

  assign col9  = {1'b0, x_r} + {5'b00000, col_i};
  assign top10 = {2'b00, y_r} + {5'b00000, row_j, 3'b000};
  assign room  = ROWS10 - top10;
  assign hrem  = h - {row_j, 3'b000};

  always_comb begin
    if (col9 >= COLS9 || top10 >= ROWS10) lim = 4'd0;
    else if (room < 10'd8) lim = room[3:0];
    else lim = 4'd8;
  end

  assign pix   = inv_r ? ~rdata : rdata;
  assign hmask = low_mask(hrem) & low_mask({1'b0, lim});
  assign smask = inv_r ? hmask : (rdata & hmask);

  assign sts.byte_stop  = !fast_r && (lim < 4'd8);
  assign sts.byte_final = (row_j == bh - 2'd1) && ({1'b0, col_i} == vw - 5'd1);
  assign sts.out_free   = !out_valid || out_ready;

  // Draw state updates.
  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.start_draw) begin
      x_r    <= pos_x;
      y_r    <= pos_y;
      fast_r <= fast_mode;
      inv_r  <= invert;
      prod   <= slot_prod[13:0];
      clip_r <= 1'b0;
    end
    if (cmd.reduce && !sts.mod_done) prod <= prod - 14'(FB17);
    if (cmd.load_width) begin
      vw    <= vw_c;
      col_i <= 4'd0;
      row_j <= 2'd0;
    end
    if (cmd.emit_byte) begin
      clip_r <= sts.byte_stop;
      if (row_j == bh - 2'd1) begin
        row_j <= 2'd0;
        col_i <= col_i + 4'd1;
      end else begin
        row_j <= row_j + 2'd1;
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_done || (cmd.emit_byte && (fast_r || lim != 4'd0))) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_done) begin
      kind        <= KIND_DONE;
      column      <= 8'd0;
      row         <= 8'd0;
      pixels      <= 8'd0;
      write_mask  <= 8'd0;
      glyph_width <= clip_r ? 5'd0 : vw;
      clipped     <= clip_r;
      last        <= 1'b1;
    end else if (cmd.emit_byte) begin
      column      <= col9[7:0];
      glyph_width <= 5'd0;
      clipped     <= 1'b0;
      last        <= 1'b0;
      if (fast_r) begin
        kind       <= KIND_PAGE;
        row        <= y_r + {6'd0, row_j};
        pixels     <= pix;
        write_mask <= 8'hFF;
      end else begin
        kind       <= KIND_PIXEL;
        row        <= top10[7:0];
        pixels     <= pix & smask;
        write_mask <= smask;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/font_glyph_renderer_core.sv @@
// Font glyph renderer: a load beat writes one font byte; a draw beat reduces the
// slot offset modulo FONT_BYTES, reads the width byte and emits the glyph bytes
// column by column, stopping early when a slow-mode draw meets the display edge.
// One font byte is read per unstalled cycle; one item is worked on at a time.
// Reset clears the controller, the output valid flag and the configuration
// registers; the font memory holds no reset value and must be loaded first.
`default_nettype none

module font_glyph_renderer_core
  import fgr_pkg::*;
#(
  parameter int FONT_BYTES      = FONT_BYTES_DEF,
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF,
  parameter int DISPLAY_ROWS    = DISPLAY_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [11:0] font_addr,
  input  wire logic [7:0]  font_byte,
  input  wire logic [7:0]  pos_x,
  input  wire logic [7:0]  pos_y,
  input  wire logic [7:0]  char_code,
  input  wire logic        fast_mode,
  input  wire logic        invert,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       column,
  output logic [7:0]       row,
  output logic [7:0]       pixels,
  output logic [7:0]       write_mask,
  output logic [4:0]       glyph_width,
  output logic             clipped,
  output logic             last
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  fgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Font memory, counters and output register.
  fgr_datapath #(
    .FONT_BYTES      (FONT_BYTES),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .DISPLAY_ROWS    (DISPLAY_ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .font_addr   (font_addr),
    .font_byte   (font_byte),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .char_code   (char_code),
    .fast_mode   (fast_mode),
    .invert      (invert),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .column      (column),
    .row         (row),
    .pixels      (pixels),
    .write_mask  (write_mask),
    .glyph_width (glyph_width),
    .clipped     (clipped),
    .last        (last)
  );

  // A draw beat keeps the input side closed on the following cycle.
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_DRAW |=> !in_ready)
    else $error("input ready right after a draw beat");

  // A load beat leaves the input side open on the following cycle.
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_LOAD |=> in_ready)
    else $error("input not ready after a load beat");

  // A clipped result is always the final done beat with zero width.
  a_clip_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> kind == KIND_DONE && last && glyph_width == 5'd0)
    else $error("clipped flag on a result that is not a zero-width done beat");

endmodule

`default_nettype wire
